@@ rtl/pooled_slot_allocator_top_assert.svh @@
// Assertion macros for the slot allocator top level.
// Each macro samples on the rising edge of clk and is held off while arst_n is low.
`ifndef POOLED_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define POOLED_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// Checks a property that holds in the same cycle.
`define PSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks a consequence in the cycle after its trigger.
`define PSA_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/psa_pkg.sv @@
`timescale 1ns / 1ps

package psa_pkg;

	// Pool geometry.
	localparam int POOLS = 8;
	localparam int SLOTS = 256;

	// Field widths.
	localparam int POOL_W   = $clog2(POOLS);
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int COUNT_W  = SLOT_W + 1;
	localparam int STATUS_W = 2;

	// The active bits are stored as rows of ROW_W bits.
	localparam int ROW_W         = 32;
	localparam int ROW_BIT_W     = $clog2(ROW_W);
	localparam int ROWS_PER_POOL = SLOTS / ROW_W;
	localparam int ROW_SEL_W     = $clog2(ROWS_PER_POOL);
	localparam int ROWS          = POOLS * ROWS_PER_POOL;
	localparam int ROW_ADDR_W    = $clog2(ROWS);

	// Free stack memory.
	localparam int CELLS      = POOLS * SLOTS;
	localparam int STK_ADDR_W = $clog2(CELLS);

	localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(SLOTS);

	// Commands.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_ALLOC   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FREED   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_POP,
		S_SET,
		S_FREE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_RESULT
	} state_t;

	// Result of a search for the highest set bit in a row.
	typedef struct packed {
		logic                 found;
		logic [ROW_BIT_W-1:0] idx;
	} top_bit_t;

	// Finds the highest set bit of a row.
	function automatic top_bit_t find_top_bit(input logic [ROW_W-1:0] row);
		top_bit_t res;
		res.found = 1'b0;
		res.idx   = '0;
		for (int i = 0; i < ROW_W; i++) begin
			if (row[i]) begin
				res.found = 1'b1;
				res.idx   = ROW_BIT_W'(i);
			end
		end
		return res;
	endfunction

	// Mask of the bits at and below a position.
	function automatic logic [ROW_W-1:0] low_mask(input logic [ROW_BIT_W-1:0] pos);
		logic [ROW_BIT_W-1:0] sh;
		sh = ROW_BIT_W'(ROW_W - 1) - pos;
		return {ROW_W{1'b1}} >> sh;
	endfunction

endpackage

@@ rtl/psa_if.sv @@
`timescale 1ns / 1ps

// Request channel: one word per allocate or free.
interface psa_req_if
	import psa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              command;
	logic [POOL_W-1:0] pool;
	logic [SLOT_W-1:0] slot_index;

	modport source (output valid, command, pool, slot_index, input ready);
	modport sink (input valid, command, pool, slot_index, output ready);
endinterface

// Response channel: one word per request.
interface psa_rsp_if
	import psa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   slot;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  active_count;

	modport source (output valid, slot, status, active_count, input ready);
	modport sink (input valid, slot, status, active_count, output ready);
endinterface

// Configuration write channel for the capacity limit.
interface psa_cfg_if
	import psa_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/pooled_slot_allocator_top.sv @@
// Channel | Dir | Word                                  | Accepted when
// req     | in  | command, pool, slot_index             | req.valid && req.ready
// rsp     | out | slot, status, active_count            | rsp.valid && rsp.ready
// cfg     | in  | data (capacity_limit)                 | cfg.valid && cfg.ready
//
// One request is in flight at a time. An allocate runs S_LOOKUP, S_POP if it pops the free
// stack, S_SET, S_RESULT; a full pool goes from S_LOOKUP to S_RESULT. A free goes to S_RESULT
// from S_LOOKUP when the slot lies at or above the capacity, from S_FREE when it is inactive,
// else goes on from S_FREE to S_SCAN_RD and S_SCAN_CHK, once per row the high-water scan reads.
// A held response word lets one more request in; that request then waits until it is taken.
// After reset a clearing pass zeroes the 64 rows of active bits; no request is taken.
`timescale 1ns / 1ps

module pooled_slot_allocator_top
	import psa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	psa_req_if.sink   req,
	psa_rsp_if.source rsp,
	psa_cfg_if.sink   cfg
);

	state_t state_q, state_nx;

	// Memories: active bits in rows, free stack entries.
	logic [ROW_W-1:0]  act_mem [ROWS];
	logic [SLOT_W-1:0] stk_mem [CELLS];

	logic                  act_re, act_we;
	logic [ROW_ADDR_W-1:0] act_raddr, act_waddr;
	logic [ROW_W-1:0]      act_wdata, act_rd_q;
	logic                  stk_re, stk_we;
	logic [STK_ADDR_W-1:0] stk_raddr, stk_waddr;
	logic [SLOT_W-1:0]     stk_wdata, stk_rd_q;

	// Per-pool counters.
	logic [COUNT_W-1:0] free_depth_q [POOLS];
	logic [COUNT_W-1:0] high_water_q [POOLS];

	// Capacity register and clearing counter.
	logic [COUNT_W-1:0]    cap_q, usable;
	logic [ROW_ADDR_W-1:0] clr_cnt_q;

	// Working registers of the item in flight.
	logic                cmd_q;
	logic [POOL_W-1:0]   pool_q;
	logic [SLOT_W-1:0]   sidx_q, slot_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  hw_q;

	// Response register.
	logic                rsp_valid_q, rsp_load;
	logic [SLOT_W-1:0]   rsp_slot_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [COUNT_W-1:0]  rsp_count_q;

	// Derived values.
	logic [COUNT_W-1:0] cur_depth, depth_dec, hw_m1, hw_set;
	logic [ROW_W-1:0]   free_row, scan_row;
	top_bit_t           scan_top;
	logic               free_hit;

	assign usable    = (cap_q > COUNT_W'(SLOTS)) ? COUNT_W'(SLOTS) : cap_q;
	assign cur_depth = free_depth_q[pool_q];
	assign depth_dec = cur_depth - COUNT_W'(1);
	assign hw_m1     = hw_q - COUNT_W'(1);
	assign free_row  = act_rd_q & ~(ROW_W'(1) << sidx_q[ROW_BIT_W-1:0]);
	assign free_hit  = act_rd_q[sidx_q[ROW_BIT_W-1:0]];
	assign scan_row  = act_rd_q & low_mask(hw_m1[ROW_BIT_W-1:0]);
	assign scan_top  = find_top_bit(scan_row);
	assign hw_set    = (({1'b0, slot_q} + COUNT_W'(1)) > hw_q) ?
		({1'b0, slot_q} + COUNT_W'(1)) : hw_q;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid        = rsp_valid_q;
	assign rsp.slot         = rsp_slot_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.active_count = rsp_count_q;

	// Active-bit memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (act_we) begin
			act_mem[act_waddr] <= act_wdata;
		end
		if (act_re) begin
			act_rd_q <= act_mem[act_raddr];
		end
	end

	// Free stack memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_raddr];
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and memory controls.
	always_comb begin
		state_nx  = state_q;
		act_re    = 1'b0;
		act_raddr = '0;
		act_we    = 1'b0;
		act_waddr = '0;
		act_wdata = '0;
		stk_re    = 1'b0;
		stk_raddr = '0;
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = sidx_q;
		rsp_load  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				act_we    = 1'b1;
				act_waddr = clr_cnt_q;
				if (clr_cnt_q == ROW_ADDR_W'(ROWS - 1)) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req.valid) begin
					state_nx = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (cmd_q == CMD_ALLOC) begin
					if (cur_depth != '0) begin
						stk_re    = 1'b1;
						stk_raddr = {pool_q, depth_dec[SLOT_W-1:0]};
						state_nx  = S_POP;
					end else if (hw_q >= usable) begin
						state_nx = S_RESULT;
					end else begin
						act_re    = 1'b1;
						act_raddr = {pool_q, hw_q[SLOT_W-1 -: ROW_SEL_W]};
						state_nx  = S_SET;
					end
				end else begin
					if ({1'b0, sidx_q} >= usable) begin
						state_nx = S_RESULT;
					end else begin
						act_re    = 1'b1;
						act_raddr = {pool_q, sidx_q[SLOT_W-1 -: ROW_SEL_W]};
						state_nx  = S_FREE;
					end
				end
			end
			S_POP: begin
				act_re    = 1'b1;
				act_raddr = {pool_q, stk_rd_q[SLOT_W-1 -: ROW_SEL_W]};
				state_nx  = S_SET;
			end
			S_SET: begin
				act_we    = 1'b1;
				act_waddr = {pool_q, slot_q[SLOT_W-1 -: ROW_SEL_W]};
				act_wdata = act_rd_q | (ROW_W'(1) << slot_q[ROW_BIT_W-1:0]);
				state_nx  = S_RESULT;
			end
			S_FREE: begin
				if (!free_hit) begin
					state_nx = S_RESULT;
				end else begin
					act_we    = 1'b1;
					act_waddr = {pool_q, sidx_q[SLOT_W-1 -: ROW_SEL_W]};
					act_wdata = free_row;
					stk_we    = (cur_depth < COUNT_W'(SLOTS));
					stk_waddr = {pool_q, cur_depth[SLOT_W-1:0]};
					state_nx  = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				act_re    = 1'b1;
				act_raddr = {pool_q, hw_m1[SLOT_W-1 -: ROW_SEL_W]};
				state_nx  = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (scan_top.found || hw_m1[SLOT_W-1 -: ROW_SEL_W] == '0) begin
					state_nx = S_RESULT;
				end else begin
					state_nx = S_SCAN_RD;
				end
			end
			S_RESULT: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data;
		end
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (state_q == S_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + ROW_ADDR_W'(1);
		end
	end

	// Per-pool counters: depth moves on pop and push, high water on completion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POOLS; i++) begin
				free_depth_q[i] <= '0;
				high_water_q[i] <= '0;
			end
		end else begin
			if (state_q == S_LOOKUP && cmd_q == CMD_ALLOC && cur_depth != '0) begin
				free_depth_q[pool_q] <= depth_dec;
			end
			if (state_q == S_FREE && free_hit && cur_depth < COUNT_W'(SLOTS)) begin
				free_depth_q[pool_q] <= cur_depth + COUNT_W'(1);
			end
			if (rsp_load) begin
				high_water_q[pool_q] <= hw_q;
			end
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= CMD_ALLOC;
			pool_q   <= '0;
			sidx_q   <= '0;
			slot_q   <= '0;
			status_q <= STATUS_IGNORED;
			hw_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q    <= req.command;
						pool_q   <= req.pool;
						sidx_q   <= req.slot_index;
						slot_q   <= req.slot_index;
						status_q <= STATUS_IGNORED;
						hw_q     <= high_water_q[req.pool];
					end
				end
				S_LOOKUP: begin
					if (cmd_q == CMD_ALLOC && cur_depth == '0) begin
						if (hw_q >= usable) begin
							slot_q   <= '0;
							status_q <= STATUS_FULL;
						end else begin
							slot_q <= hw_q[SLOT_W-1:0];
						end
					end
				end
				S_POP: begin
					slot_q <= stk_rd_q;
				end
				S_SET: begin
					hw_q     <= hw_set;
					status_q <= STATUS_ALLOC;
				end
				S_FREE: begin
					if (free_hit) begin
						status_q <= STATUS_FREED;
					end
				end
				S_SCAN_CHK: begin
					if (scan_top.found) begin
						hw_q <= {1'b0, hw_m1[SLOT_W-1 -: ROW_SEL_W], scan_top.idx} +
							COUNT_W'(1);
					end else begin
						hw_q <= {1'b0, hw_m1[SLOT_W-1 -: ROW_SEL_W], {ROW_BIT_W{1'b0}}};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Response register: loads when empty or when the held word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_slot_q   <= slot_q;
			rsp_status_q <= status_q;
			rsp_count_q  <= hw_q;
		end
	end

	// Assertions.
	`include "pooled_slot_allocator_top_assert.svh"

	`PSA_ASSERT(a_alloc_covered, !(rsp.valid && rsp.status == STATUS_ALLOC) || (rsp.active_count > {1'b0, rsp.slot}), "allocated slot lies at or above the high-water count")
	`PSA_ASSERT(a_freed_trailing, !(rsp.valid && rsp.status == STATUS_FREED) || (rsp.active_count != ({1'b0, rsp.slot} + COUNT_W'(1))), "high-water count still covers the freed slot")
	`PSA_ASSERT(a_depth_bound, free_depth_q[pool_q] <= COUNT_W'(SLOTS), "free stack depth above the slot count")
	`PSA_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second request taken while one is in flight")

endmodule
